// ----- rtl/dpr_pkg.sv -----
// Package for the DDA polygon rasterizer: widths, command codes and the
// point rounding function. No dependencies.
package dpr_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;

  // Q(COORD_BITS+1).FRAC_BITS signed accumulator
  localparam int ACC_W   = COORD_BITS + 1 + FRAC_BITS;
  // signed increment: sign, one integer bit, FRAC_BITS fraction bits
  localparam int INC_W   = FRAC_BITS + 2;
  // divider numerator: (|d| << FRAC_BITS) + steps/2
  localparam int NUM_W   = COORD_BITS + FRAC_BITS + 1;
  localparam int STEPS_W = COORD_BITS + 1;
  localparam int DCNT_W  = $clog2(NUM_W + 1);

  localparam int S_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_NEXT  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;
  localparam logic [1:0] CMD_STEP  = 2'd3;

  typedef logic [COORD_BITS-1:0]   coord_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [INC_W-1:0] inc_t;

  // Round to nearest (halves up) and saturate to [0, 2^COORD_BITS-1].
  function automatic coord_t round_point(input acc_t acc);
    logic signed [ACC_W:0] biased;
    coord_t                p;
    biased = {acc[ACC_W-1], acc} + (ACC_W + 1)'(1 << (FRAC_BITS - 1));
    if (biased[ACC_W]) begin
      p = '0;
    end else if (biased[ACC_W-1]) begin
      p = '1;
    end else begin
      p = biased[ACC_W-2:FRAC_BITS];
    end
    return p;
  endfunction

endpackage

// ----- rtl/dpr_divider.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on dpr_pkg for the numerator and coordinate widths.
module dpr_divider
  import dpr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  coord_t           den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0]    num_sr;
  logic [COORD_BITS:0] rem;
  coord_t              den_q;
  logic [DCNT_W-1:0]   cnt;
  logic                busy;

  logic [COORD_BITS:0] trial;
  logic                ge;

  // shift the next numerator bit into the partial remainder
  assign trial = {rem[COORD_BITS-1:0], num_sr[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sr <= num;
      den_q  <= den;
      rem    <= '0;
    end else if (busy) begin
      num_sr <= {num_sr[NUM_W-2:0], 1'b0};
      rem    <= ge ? trial - {1'b0, den_q} : trial;
      quo    <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/dda_polygon_rasterizer.sv -----
// Top level of the DDA polygon rasterizer: command decode, vertex state,
// the two accumulators and the output register. Uses dpr_pkg, dpr_divider.
//
//  channel | dir | tdata (low bit up)   | tuser / tlast
//  --------+-----+----------------------+----------------------------
//  s_*     | in  | vx, vy, zero pad     | tuser = cmd
//  m_*     | out | px, py, zero pad     | tlast = last_point
//
// Begin and step items do not stall the input.
// Segment and close items of nonzero length run both increment divisions in
// parallel on bit-serial dividers: the input stalls until both are done,
// one quotient bit per cycle.
// A zero-length segment does not stall the input.
// The output register holds a point until taken; a new item is accepted only
// while the register is empty or being drained.
// rst is synchronous, active high, and leaves no segment active.
module dda_polygon_rasterizer
  import dpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] vx, [19:10] vy, rest zero
  input  logic [1:0]           s_tuser,   // [1:0] cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [9:0] px, [19:10] py, rest zero
  output logic                 m_tlast    // last_point
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic state;

  coord_t               first_vx, first_vy, cur_vx, cur_vy;
  acc_t                 acc_x, acc_y;
  inc_t                 inc_x, inc_y;
  logic [STEPS_W-1:0]   steps_left;
  logic                 seg_active;
  logic                 neg_x, neg_y;
  coord_t               px, py;

  logic                 s_fire;
  logic                 point_fire;
  logic [1:0]           cmd;
  coord_t               vx, vy, tx, ty;
  logic [COORD_BITS:0]  dx, dy;
  coord_t               ax, ay, steps;
  logic [NUM_W-1:0]     num_x, num_y, quo_x, quo_y;
  logic                 div_start, div_done_x, div_done_y;
  logic [INC_W-1:0]     qx, qy;

  assign cmd = s_tuser;
  assign vx  = s_tdata[COORD_BITS-1:0];
  assign vy  = s_tdata[2*COORD_BITS-1:COORD_BITS];

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign s_fire   = s_tvalid && s_tready;

  // a step on an active segment loads a point into the output register
  assign point_fire = s_fire && (cmd == CMD_STEP) && seg_active
                      && (steps_left != '0);

  // segment set-up: target, differences, magnitudes, step count
  assign tx = (cmd == CMD_CLOSE) ? first_vx : vx;
  assign ty = (cmd == CMD_CLOSE) ? first_vy : vy;
  assign dx = {1'b0, tx} - {1'b0, cur_vx};
  assign dy = {1'b0, ty} - {1'b0, cur_vy};
  assign ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
  assign ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
  assign steps = (ax > ay) ? ax : ay;

  // numerator rounds the quotient to nearest: add half the divisor
  assign num_x = {1'b0, ax, {FRAC_BITS{1'b0}}} + NUM_W'(steps >> 1);
  assign num_y = {1'b0, ay, {FRAC_BITS{1'b0}}} + NUM_W'(steps >> 1);

  assign div_start = s_fire && (cmd == CMD_NEXT || cmd == CMD_CLOSE)
                     && (steps != '0);

  dpr_divider u_div_x (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num_x),
    .den  (steps),
    .done (div_done_x),
    .quo  (quo_x)
  );

  dpr_divider u_div_y (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num_y),
    .den  (steps),
    .done (div_done_y),
    .quo  (quo_y)
  );

  // quotient never exceeds 2^FRAC_BITS, so the low bits hold it whole
  assign qx = quo_x[INC_W-1:0];
  assign qy = quo_y[INC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      first_vx   <= '0;
      first_vy   <= '0;
      cur_vx     <= '0;
      cur_vy     <= '0;
      acc_x      <= '0;
      acc_y      <= '0;
      inc_x      <= '0;
      inc_y      <= '0;
      steps_left <= '0;
      seg_active <= 1'b0;
      neg_x      <= 1'b0;
      neg_y      <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // load a new point, else drain the output register
      if (point_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            unique case (cmd)
              CMD_BEGIN: begin
                // store both vertices and drop any active segment
                first_vx   <= vx;
                first_vy   <= vy;
                cur_vx     <= vx;
                cur_vy     <= vy;
                seg_active <= 1'b0;
                steps_left <= '0;
              end
              CMD_NEXT, CMD_CLOSE: begin
                acc_x      <= acc_t'({1'b0, cur_vx, {FRAC_BITS{1'b0}}});
                acc_y      <= acc_t'({1'b0, cur_vy, {FRAC_BITS{1'b0}}});
                cur_vx     <= tx;
                cur_vy     <= ty;
                seg_active <= 1'b1;
                neg_x      <= dx[COORD_BITS];
                neg_y      <= dy[COORD_BITS];
                if (steps == '0) begin
                  // zero length: emit the start point once
                  steps_left <= STEPS_W'(1);
                  inc_x      <= '0;
                  inc_y      <= '0;
                end else begin
                  steps_left <= STEPS_W'(steps);
                  state      <= ST_DIV;
                end
              end
              CMD_STEP: begin
                if (point_fire) begin
                  m_tlast    <= (steps_left == STEPS_W'(1));
                  px         <= round_point(acc_x);
                  py         <= round_point(acc_y);
                  acc_x      <= acc_x + {{(ACC_W-INC_W){inc_x[INC_W-1]}}, inc_x};
                  acc_y      <= acc_y + {{(ACC_W-INC_W){inc_y[INC_W-1]}}, inc_y};
                  steps_left <= steps_left - 1'b1;
                  if (steps_left == STEPS_W'(1)) begin
                    seg_active <= 1'b0;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV: begin
          // both dividers run in lockstep; apply the signs once done
          if (div_done_x && div_done_y) begin
            inc_x <= neg_x ? -qx : qx;
            inc_y <= neg_y ? -qy : qy;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = M_TDATA_W'({py, px});

endmodule

// ----- rtl/dpr_checker.sv -----
// Port-level checker for the DDA polygon rasterizer, bound to the top level.
// Depends on dpr_pkg for widths and command codes.
module dpr_checker
  import dpr_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic [1:0]           s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tlast
);

  // hold a stalled point
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  // no new item while a point waits
  a_in_blocked: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output register full");

  // a point appears only after an accepted step
  a_point_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser == CMD_STEP))
    else $error("point without an accepted step");

  // a vertex command never yields a point
  a_no_point_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != CMD_STEP |=> !$rose(m_tvalid))
    else $error("point produced by a vertex command");

endmodule

bind dda_polygon_rasterizer dpr_checker u_dpr_checker (.*);

// ----- test/dpr_point_checker.sv -----
// Scoreboard for the DDA polygon rasterizer: watches both stream channels,
// predicts each point from the accepted commands and compares in order.
// Depends on dpr_pkg for widths, command codes and the coord/acc/inc types.
module dpr_point_checker
  import dpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [1:0]           s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 m_tlast,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    coord_t px;
    coord_t py;
    logic   tail;
  } point_t;

  point_t             expected_points[$];
  coord_t             anchor_x, anchor_y;
  coord_t             pen_x, pen_y;
  acc_t               acc_x, acc_y;
  inc_t               inc_x, inc_y;
  logic [STEPS_W-1:0] steps_left;
  logic               drawing;
  int                 fails;

  initial begin
    fails = 0;
  end

  // Per-step increment: |d| scaled by 2^FRAC_BITS over the span, rounded
  // half away from zero, sign restored afterwards.
  function automatic inc_t slope_inc(input int d, input int span);
    longint mag;
    longint q;
    mag = longint'(d < 0 ? -d : d) << FRAC_BITS;
    q   = (mag + span / 2) / span;
    return inc_t'(d < 0 ? -q : q);
  endfunction

  // Round halves up, clamp to the coordinate range.
  function automatic coord_t to_pixel(input acc_t acc);
    longint biased;
    biased = longint'(acc) + (longint'(1) << (FRAC_BITS - 1));
    if (biased < 0) return '0;
    if ((biased >> FRAC_BITS) > longint'((1 << COORD_BITS) - 1)) return '1;
    return coord_t'(biased >> FRAC_BITS);
  endfunction

  task automatic open_segment(input coord_t tx, input coord_t ty);
    int dx;
    int dy;
    int span;
    dx    = int'(tx) - int'(pen_x);
    dy    = int'(ty) - int'(pen_y);
    span  = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                      : (dy < 0 ? -dy : dy);
    acc_x = acc_t'(longint'(pen_x) << FRAC_BITS);
    acc_y = acc_t'(longint'(pen_y) << FRAC_BITS);
    if (span == 0) begin
      // zero-length: one step, start point only
      span  = 1;
      inc_x = '0;
      inc_y = '0;
    end else begin
      inc_x = slope_inc(dx, span);
      inc_y = slope_inc(dy, span);
    end
    steps_left = STEPS_W'(span);
    drawing    = 1'b1;
    pen_x      = tx;
    pen_y      = ty;
  endtask

  task automatic rasterize_item(input logic [1:0] cmd, input coord_t x, input coord_t y);
    point_t pt;
    case (cmd)
      CMD_BEGIN: begin
        anchor_x   = x;
        anchor_y   = y;
        pen_x      = x;
        pen_y      = y;
        drawing    = 1'b0;
        steps_left = '0;
      end
      CMD_NEXT:  open_segment(x, y);
      CMD_CLOSE: open_segment(anchor_x, anchor_y);
      default: begin
        if (drawing && steps_left != 0) begin
          pt.px   = to_pixel(acc_x);
          pt.py   = to_pixel(acc_y);
          pt.tail = (steps_left == 1);
          expected_points.push_back(pt);
          acc_x      = acc_x + acc_t'(inc_x);
          acc_y      = acc_y + acc_t'(inc_y);
          steps_left = steps_left - 1'b1;
          if (steps_left == 0) drawing = 1'b0;
        end
      end
    endcase
  endtask

  task automatic check_point(input point_t got);
    point_t want;
    if (expected_points.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("unexpected point px=%0d py=%0d last=%0b", got.px, got.py, got.tail);
    end else begin
      want = expected_points.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10)
          $display("point mismatch: expected px=%0d py=%0d last=%0b, got px=%0d py=%0d last=%0b",
                   want.px, want.py, want.tail, got.px, got.py, got.tail);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      anchor_x   = '0;
      anchor_y   = '0;
      pen_x      = '0;
      pen_y      = '0;
      acc_x      = '0;
      acc_y      = '0;
      inc_x      = '0;
      inc_y      = '0;
      steps_left = '0;
      drawing    = 1'b0;
      expected_points.delete();
    end else begin
      // output is registered, so a point never answers a command of this edge
      if (m_tvalid && m_tready)
        check_point({m_tdata[COORD_BITS-1:0], m_tdata[2*COORD_BITS-1:COORD_BITS], m_tlast});
      if (s_tvalid && s_tready)
        rasterize_item(s_tuser, s_tdata[COORD_BITS-1:0], s_tdata[2*COORD_BITS-1:COORD_BITS]);
    end
    fail_count <= fails;
    pending    <= expected_points.size();
  end

endmodule

// ----- test/tb_top.sv -----
// Top of the rasterizer testbench: clock, reset, command stimulus, output
// back-pressure, watchdog and verdict. Uses dpr_pkg, dpr_point_checker and
// the dda_polygon_rasterizer RTL.
module tb_top;
  import dpr_pkg::*;

  localparam int CMAX     = (1 << COORD_BITS) - 1;
  localparam int N_ITEMS  = 1150;
  // longest quiet stretch of a correct run is a sender gap, a divider
  // stall and a receiver stall together; allow many times that
  localparam int WATCHDOG = 2000;

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [1:0]           s_tuser  = CMD_BEGIN;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  int     fail_count;
  int     pending;
  int     items_sent  = 0;
  int     idle_cycles = 0;
  int     stall_left  = 0;
  bit     calm        = 1'b0;
  // where the stimulus thinks the pen and the first vertex are;
  // used to size the step runs and to pick targets near the pen
  coord_t poly_x, poly_y, pen_x, pen_y;

  dda_polygon_rasterizer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  dpr_point_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Pause length: mostly short, now and then a long one.
  function automatic int pick_pause(input int long_lo, input int long_hi);
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(long_lo, long_hi);
  endfunction

  // Receiver: hold ready low for random stretches, none while calm.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left <= pick_pause(8, 30);
    end
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG - 1) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic coord_t any_coord();
    return coord_t'($urandom_range(0, CMAX));
  endfunction

  // Present one item, wait for its handshake, then maybe idle.
  // Valid stays high when no gap follows, so back-to-back items never
  // lower and raise it in the same step.
  task automatic send(input logic [1:0] cmd, input coord_t x, input coord_t y,
                      input bit counted);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= S_TDATA_W'({y, x});
    do @(posedge clk); while (!s_tready);
    if (counted) items_sent++;
    // every fourth stretch of 150 items runs with no idling at all
    calm = ((items_sent / 150) % 4) == 3;
    gap  = 0;
    if (!calm && $urandom_range(0, 99) >= 60) gap = pick_pause(8, 40);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every predicted point has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Random target near the pen; rarely anywhere, which makes a long segment.
  function automatic coord_t nudge(input coord_t base);
    int r;
    int v;
    r = $urandom_range(0, 999);
    if (r < 3) return any_coord();
    if (r < 750) v = int'(base) + $urandom_range(0, 12) - 6;
    else v = int'(base) + $urandom_range(0, 80) - 40;
    if (v < 0) v = 0;
    if (v > CMAX) v = CMAX;
    return coord_t'(v);
  endfunction

  // Issue a segment or close command, then a run of steps: usually the
  // full span, sometimes cut short, sometimes overrunning into ignored steps.
  task automatic draw_to(input logic [1:0] cmd, input coord_t tx, input coord_t ty);
    int dx;
    int dy;
    int span;
    int runs;
    int r;
    dx   = int'(tx) - int'(pen_x);
    dy   = int'(ty) - int'(pen_y);
    dx   = dx < 0 ? -dx : dx;
    dy   = dy < 0 ? -dy : dy;
    span = dx > dy ? dx : dy;
    if (span == 0) span = 1;
    send(cmd, cmd == CMD_CLOSE ? any_coord() : tx, cmd == CMD_CLOSE ? any_coord() : ty, 1'b1);
    pen_x = tx;
    pen_y = ty;
    r = $urandom_range(0, 99);
    if (r < 80) runs = span;
    else if (r < 90) runs = $urandom_range(0, span - 1);
    else runs = span + $urandom_range(1, 2);
    for (int i = 0; i < runs; i++)
      send(CMD_STEP, any_coord(), any_coord(), i < span);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // step with no segment: no point
    send(CMD_STEP, 10'd1023, 10'd1023, 1'b1);
    // close before any begin: zero-length at the origin, one point
    send(CMD_CLOSE, 10'd0, 10'd0, 1'b1);
    send(CMD_STEP, any_coord(), any_coord(), 1'b1);
    send(CMD_STEP, any_coord(), any_coord(), 1'b1);
    // segment before any begin starts from the reset vertex; cut it short
    send(CMD_NEXT, 10'd3, 10'd2, 1'b1);
    repeat (2) send(CMD_STEP, any_coord(), any_coord(), 1'b1);
    // top corner, short diagonal, then a long segment interrupted by begin
    send(CMD_BEGIN, 10'd1023, 10'd1023, 1'b1);
    send(CMD_NEXT, 10'd1021, 10'd1020, 1'b1);
    send(CMD_STEP, any_coord(), any_coord(), 1'b1);
    send(CMD_NEXT, 10'd1023, 10'd0, 1'b1);
    repeat (2) send(CMD_STEP, any_coord(), any_coord(), 1'b1);
    send(CMD_BEGIN, 10'd0, 10'd1023, 1'b1);
    send(CMD_STEP, any_coord(), any_coord(), 1'b1);
    // zero-length segment to the same vertex
    send(CMD_NEXT, 10'd0, 10'd1023, 1'b1);
    send(CMD_STEP, any_coord(), any_coord(), 1'b1);
    // partial segment, then close back to the first vertex and overrun it
    send(CMD_NEXT, 10'd5, 10'd1021, 1'b1);
    repeat (2) send(CMD_STEP, any_coord(), any_coord(), 1'b1);
    send(CMD_CLOSE, any_coord(), any_coord(), 1'b1);
    repeat (6) send(CMD_STEP, any_coord(), any_coord(), 1'b1);
    drain();

    // --- random polygons with some noise ---
    while (items_sent < N_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send(2'($urandom_range(0, 3)), any_coord(), any_coord(), 1'b1);
      end else begin
        poly_x = any_coord();
        poly_y = any_coord();
        pen_x  = poly_x;
        pen_y  = poly_y;
        send(CMD_BEGIN, poly_x, poly_y, 1'b1);
        repeat ($urandom_range(1, 5)) draw_to(CMD_NEXT, nudge(pen_x), nudge(pen_y));
        if ($urandom_range(0, 4) != 0) draw_to(CMD_CLOSE, poly_x, poly_y);
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    // --- wind down: wait for the last points, then past a divider stall ---
    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
